[rtl/lbps_pkg.sv]
// Shared types and constants for the least busy port scheduler.
package lbps_pkg;

   // Port set sizes
   localparam int READ_PORTS_DEFAULT  = 4;
   localparam int WRITE_PORTS_DEFAULT = 4;

   // Field widths
   localparam int TICK_W      = 48;
   localparam int COUNT_W     = 10;
   localparam int LAT_W       = 8;
   localparam int PERIOD_W    = 16;
   localparam int DELAY_W     = 32;
   localparam int PORT_IDX_W  = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int LAT_ACC_W   = LAT_W + COUNT_W;
   localparam int BUSY_W      = LAT_ACC_W + PERIOD_W;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
   localparam logic [LAT_W-1:0] LAT_RESET = LAT_W'(1);

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_LATENCY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_LATENCY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_PERIOD  = 2'd2;

   // Request kinds
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_ACC,
      ST_MUL_PERIOD,
      ST_START,
      ST_END,
      ST_WAIT,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

[rtl/least_busy_port_scheduler_top.sv]
// Least busy port scheduler: port scan, busy time and cycle conversion on one shared adder.
// After start is taken, rsp_strobe follows the scan, multiply, start, end, wait, divide and done states in turn.
// No new request is taken until the last one is done; the 48-step restoring divider takes most of each one.
// busy stays high until the strobe cycle; csr writes are held off while busy is high.
// Each result is on the rsp_ ports for one cycle under rsp_strobe; the receiver cannot stall.
// Reset (synchronous, active high) clears port free ticks, latencies 1, period 1000 ticks.
module least_busy_port_scheduler_top #(
   parameter int READ_PORTS  = lbps_pkg::READ_PORTS_DEFAULT,
   parameter int WRITE_PORTS = lbps_pkg::WRITE_PORTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [lbps_pkg::COUNT_W-1:0]       req_access_count,
   input  logic [lbps_pkg::TICK_W-1:0]        req_now_tick,
   output logic                               rsp_strobe,
   output logic [lbps_pkg::DELAY_W-1:0]       rsp_delay_cycles,
   output logic [lbps_pkg::PORT_IDX_W-1:0]    rsp_port_index,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lbps_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int TW       = lbps_pkg::TICK_W;
   localparam int PW       = lbps_pkg::PERIOD_W;
   localparam int PORT_MAX = (READ_PORTS > WRITE_PORTS) ? READ_PORTS : WRITE_PORTS;
   localparam int CNT_W    = $clog2(PORT_MAX + 1);
   localparam int DIV_CNT_W = $clog2(TW);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TW - 1);

   // Registers
   lbps_pkg::state_type state_ff, state_in;
   logic [TW-1:0] read_free_ff [READ_PORTS];
   logic [TW-1:0] read_free_in [READ_PORTS];
   logic [TW-1:0] write_free_ff [WRITE_PORTS];
   logic [TW-1:0] write_free_in [WRITE_PORTS];
   logic [lbps_pkg::LAT_W-1:0] read_lat_ff, read_lat_in;
   logic [lbps_pkg::LAT_W-1:0] write_lat_ff, write_lat_in;
   logic [PW-1:0] period_ff, period_in;
   logic kind_ff, kind_in;
   logic [lbps_pkg::COUNT_W-1:0] acc_ff, acc_in;
   logic [TW-1:0] now_ff, now_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [lbps_pkg::PORT_IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [TW-1:0] best_val_ff, best_val_in;
   logic [lbps_pkg::LAT_ACC_W-1:0] lat_acc_ff, lat_acc_in;
   logic [lbps_pkg::BUSY_W-1:0] busy_ticks_ff, busy_ticks_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [TW-1:0] quot_ff, quot_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   logic [lbps_pkg::DELAY_W-1:0] rsp_delay_ff, rsp_delay_in;
   logic [lbps_pkg::PORT_IDX_W-1:0] rsp_port_ff, rsp_port_in;

   // Shared adder and helpers
   logic [TW-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [TW:0]   alu_res;
   logic [TW-1:0] scan_entry;
   logic [CNT_W-1:0] port_count;
   logic [lbps_pkg::LAT_W-1:0] lat_sel;
   logic [PW:0]   div_shift;
   logic          csr_write;

   // Hold off register writes while a request is in flight
   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;
   assign busy = (state_ff != lbps_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_delay_cycles = rsp_delay_ff;
   assign rsp_port_index = rsp_port_ff;

   // One 49-bit add/subtract unit; bit TW is carry on add and borrow on subtract
   assign alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(TW + 1){alu_sub}})
                    + (TW + 1)'(alu_sub);

   // Select the port entry under the scan pointer
   always_comb begin
      scan_entry = '0;
      if (kind_ff == lbps_pkg::REQ_READ) begin
         for (int i = 0; i < READ_PORTS; i++) begin
            if (scan_ff == CNT_W'(i)) begin
               scan_entry = read_free_ff[i];
            end
         end
      end else begin
         for (int i = 0; i < WRITE_PORTS; i++) begin
            if (scan_ff == CNT_W'(i)) begin
               scan_entry = write_free_ff[i];
            end
         end
      end
   end

   assign port_count = (kind_ff == lbps_pkg::REQ_READ) ? CNT_W'(READ_PORTS)
                                                       : CNT_W'(WRITE_PORTS);
   assign lat_sel = (kind_ff == lbps_pkg::REQ_READ) ? read_lat_ff : write_lat_ff;
   assign div_shift = {rem_ff, quot_ff[TW-1]};

   // Sequencer: next state, datapath steps and shared adder operands
   always_comb begin
      state_in      = state_ff;
      read_free_in  = read_free_ff;
      write_free_in = write_free_ff;
      read_lat_in   = read_lat_ff;
      write_lat_in  = write_lat_ff;
      period_in     = period_ff;
      kind_in       = kind_ff;
      acc_in        = acc_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      lat_acc_in    = lat_acc_ff;
      busy_ticks_in = busy_ticks_ff;
      tick_in       = tick_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_delay_in  = rsp_delay_ff;
      rsp_port_in   = rsp_port_ff;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b1;

      // Take register writes
      if (csr_write) begin
         unique case (csr_index)
            lbps_pkg::CSR_READ_LATENCY:  read_lat_in  = csr_data[lbps_pkg::LAT_W-1:0];
            lbps_pkg::CSR_WRITE_LATENCY: write_lat_in = csr_data[lbps_pkg::LAT_W-1:0];
            lbps_pkg::CSR_CLOCK_PERIOD:  period_in    = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         lbps_pkg::ST_IDLE: begin
            if (start) begin
               kind_in     = req_type;
               acc_in      = req_access_count;
               now_in      = req_now_tick;
               scan_in     = CNT_W'(1);
               best_idx_in = '0;
               best_val_in = (req_type == lbps_pkg::REQ_READ) ? read_free_ff[0]
                                                               : write_free_ff[0];
               state_in    = lbps_pkg::ST_SCAN;
            end
         end
         lbps_pkg::ST_SCAN: begin
            // Keep the earliest free tick; a tie keeps the lower index
            if (scan_ff == port_count) begin
               state_in = lbps_pkg::ST_MUL_ACC;
            end else begin
               alu_a = scan_entry;
               alu_b = best_val_ff;
               if (alu_res[TW]) begin
                  best_val_in = scan_entry;
                  best_idx_in = lbps_pkg::PORT_IDX_W'(scan_ff);
               end
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         lbps_pkg::ST_MUL_ACC: begin
            lat_acc_in = lbps_pkg::LAT_ACC_W'(lat_sel) * lbps_pkg::LAT_ACC_W'(acc_ff);
            state_in   = lbps_pkg::ST_MUL_PERIOD;
         end
         lbps_pkg::ST_MUL_PERIOD: begin
            busy_ticks_in = lbps_pkg::BUSY_W'(lat_acc_ff) * lbps_pkg::BUSY_W'(period_ff);
            state_in      = lbps_pkg::ST_START;
         end
         lbps_pkg::ST_START: begin
            // An idle port starts at the current tick
            alu_a    = best_val_ff;
            alu_b    = now_ff;
            tick_in  = alu_res[TW] ? now_ff : best_val_ff;
            state_in = lbps_pkg::ST_END;
         end
         lbps_pkg::ST_END: begin
            // Add busy time, saturating at the top tick, and store it back
            alu_a   = tick_ff;
            alu_b   = TW'(busy_ticks_ff);
            alu_sub = 1'b0;
            tick_in = alu_res[TW] ? lbps_pkg::TICK_MAX : alu_res[TW-1:0];
            if (kind_ff == lbps_pkg::REQ_READ) begin
               for (int i = 0; i < READ_PORTS; i++) begin
                  if (best_idx_ff == lbps_pkg::PORT_IDX_W'(i)) begin
                     read_free_in[i] = tick_in;
                  end
               end
            end else begin
               for (int i = 0; i < WRITE_PORTS; i++) begin
                  if (best_idx_ff == lbps_pkg::PORT_IDX_W'(i)) begin
                     write_free_in[i] = tick_in;
                  end
               end
            end
            state_in = lbps_pkg::ST_WAIT;
         end
         lbps_pkg::ST_WAIT: begin
            // Wait in ticks becomes the dividend; a zero period divides as one
            alu_a      = tick_ff;
            alu_b      = now_ff;
            quot_in    = alu_res[TW-1:0];
            rem_in     = '0;
            div_cnt_in = '0;
            divisor_in = (period_ff == '0) ? PW'(1) : period_ff;
            state_in   = lbps_pkg::ST_DIV;
         end
         lbps_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle
            alu_a = TW'(div_shift);
            alu_b = TW'(divisor_ff);
            if (alu_res[TW]) begin
               rem_in  = div_shift[PW-1:0];
               quot_in = {quot_ff[TW-2:0], 1'b0};
            end else begin
               rem_in  = alu_res[PW-1:0];
               quot_in = {quot_ff[TW-2:0], 1'b1};
            end
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = lbps_pkg::ST_DONE;
            end
         end
         lbps_pkg::ST_DONE: begin
            // Round up on a remainder, saturate to the output width
            alu_a   = quot_ff;
            alu_b   = TW'(rem_ff != '0);
            alu_sub = 1'b0;
            if (alu_res[TW:lbps_pkg::DELAY_W] != '0) begin
               rsp_delay_in = {lbps_pkg::DELAY_W{1'b1}};
            end else begin
               rsp_delay_in = alu_res[lbps_pkg::DELAY_W-1:0];
            end
            rsp_port_in   = best_idx_ff;
            rsp_strobe_in = 1'b1;
            state_in      = lbps_pkg::ST_IDLE;
         end
         default: state_in = lbps_pkg::ST_IDLE;
      endcase
   end

   // Control state and port free ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lbps_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         read_lat_ff   <= lbps_pkg::LAT_RESET;
         write_lat_ff  <= lbps_pkg::LAT_RESET;
         period_ff     <= lbps_pkg::PERIOD_RESET;
         for (int i = 0; i < READ_PORTS; i++) begin
            read_free_ff[i] <= '0;
         end
         for (int i = 0; i < WRITE_PORTS; i++) begin
            write_free_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         read_lat_ff   <= read_lat_in;
         write_lat_ff  <= write_lat_in;
         period_ff     <= period_in;
         read_free_ff  <= read_free_in;
         write_free_ff <= write_free_in;
      end
   end

   // Datapath words
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      acc_ff        <= acc_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      lat_acc_ff    <= lat_acc_in;
      busy_ticks_ff <= busy_ticks_in;
      tick_ff       <= tick_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_port_ff   <= rsp_port_in;
   end

   // A result strobe follows the rounding step and nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == lbps_pkg::ST_DONE))
      else $error("result strobe without a finished division");

   // A taken request starts the port scan
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == lbps_pkg::ST_SCAN))
      else $error("accepted request did not start the scan");

   // The new free tick never lies before the current tick
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbps_pkg::ST_WAIT) |-> !alu_res[TW])
      else $error("port free tick below current tick");

   // The divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbps_pkg::ST_DIV) |-> (rem_ff < divisor_ff))
      else $error("divider remainder out of range");

   // The chosen port lies within the set of its kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ((kind_ff == lbps_pkg::REQ_READ && rsp_port_ff < READ_PORTS) ||
                         (kind_ff == lbps_pkg::REQ_WRITE && rsp_port_ff < WRITE_PORTS)))
      else $error("chosen port index outside its set");

endmodule

[bench/least_busy_port_scheduler_top_tb.sv]
// Self-checking testbench for the least busy port scheduler top level.
`timescale 1ns / 100ps

module least_busy_port_scheduler_top_tb;

   localparam int READ_PORTS  = lbps_pkg::READ_PORTS_DEFAULT;
   localparam int WRITE_PORTS = lbps_pkg::WRITE_PORTS_DEFAULT;
   localparam int MAX_PORTS   = 8;
   localparam int PHASE_ITEMS = 204;
   localparam int SETTLE_CYCLES = MAX_PORTS + 64;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int REPORT_LIMIT  = 10;
   localparam longint unsigned DELAY_LIMIT = 64'hFFFF_FFFF;
   localparam longint unsigned TIMEOUT_NS  = 64'd10_000_000;
   // Index with no register behind it; writes there must change nothing
   localparam logic [lbps_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic [lbps_pkg::DELAY_W-1:0]    delay_cycles;
      logic [lbps_pkg::PORT_IDX_W-1:0] port_index;
   } grant_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic                             req_type;
   logic [lbps_pkg::COUNT_W-1:0]     req_access_count;
   logic [lbps_pkg::TICK_W-1:0]      req_now_tick;
   logic                             rsp_strobe;
   logic [lbps_pkg::DELAY_W-1:0]     rsp_delay_cycles;
   logic [lbps_pkg::PORT_IDX_W-1:0]  rsp_port_index;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [lbps_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lbps_pkg::CSR_DATA_W-1:0]  csr_data;

   // Scheduler image: port free ticks and register copies
   logic [lbps_pkg::TICK_W-1:0]   read_free_at [READ_PORTS];
   logic [lbps_pkg::TICK_W-1:0]   write_free_at [WRITE_PORTS];
   logic [lbps_pkg::LAT_W-1:0]    rd_latency;
   logic [lbps_pkg::LAT_W-1:0]    wr_latency;
   logic [lbps_pkg::PERIOD_W-1:0] period_ticks;

   grant_type       pending_grants [$];
   int              mismatch_count = 0;
   bit              sender_gaps_on = 1'b1;
   longint unsigned tick_cursor = 0;

   least_busy_port_scheduler_top #(
      .READ_PORTS (READ_PORTS),
      .WRITE_PORTS(WRITE_PORTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_access_count(req_access_count),
      .req_now_tick    (req_now_tick),
      .rsp_strobe      (rsp_strobe),
      .rsp_delay_cycles(rsp_delay_cycles),
      .rsp_port_index  (rsp_port_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pick the earliest free port of the kind, book the work on it, return the wait
   function automatic grant_type book_port(input logic kind,
                                           input logic [lbps_pkg::COUNT_W-1:0] accesses,
                                           input logic [lbps_pkg::TICK_W-1:0] now);
      logic [lbps_pkg::TICK_W-1:0] free_at [MAX_PORTS];
      int                ports;
      int                best;
      longint unsigned   lat;
      longint unsigned   free_tick;
      longint unsigned   occupancy;
      longint unsigned   span;
      longint unsigned   divisor;
      longint unsigned   cycles;
      grant_type         grant;
      if (kind == lbps_pkg::REQ_READ) begin
         ports = READ_PORTS;
         lat   = rd_latency;
         for (int i = 0; i < READ_PORTS; i++) free_at[i] = read_free_at[i];
      end else begin
         ports = WRITE_PORTS;
         lat   = wr_latency;
         for (int i = 0; i < WRITE_PORTS; i++) free_at[i] = write_free_at[i];
      end
      // Lowest index wins a tie
      best = 0;
      for (int i = 1; i < ports; i++) begin
         if (free_at[i] < free_at[best]) best = i;
      end
      // An idle port starts at the current tick
      free_tick = free_at[best];
      if (free_tick < now) free_tick = now;
      occupancy = lat * accesses * period_ticks;
      if (occupancy > 64'(lbps_pkg::TICK_MAX) - free_tick)
         free_tick = 64'(lbps_pkg::TICK_MAX);
      else free_tick = free_tick + occupancy;
      if (kind == lbps_pkg::REQ_READ) read_free_at[best] = lbps_pkg::TICK_W'(free_tick);
      else write_free_at[best] = lbps_pkg::TICK_W'(free_tick);
      // Round the wait up to whole cycles; a zero period divides as one
      span    = free_tick - now;
      divisor = (period_ticks == 0) ? 64'd1 : 64'(period_ticks);
      cycles  = span / divisor + ((span % divisor != 0) ? 64'd1 : 64'd0);
      if (cycles > DELAY_LIMIT) cycles = DELAY_LIMIT;
      grant.delay_cycles = lbps_pkg::DELAY_W'(cycles);
      grant.port_index   = lbps_pkg::PORT_IDX_W'(best);
      return grant;
   endfunction

   // Drop start and wait until every booked grant has come back
   task automatic wait_until_drained();
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [lbps_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [lbps_pkg::CSR_DATA_W-1:0] value);
      wait_until_drained();
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // Drop csr_valid and wait for a clock edge before the next write word
      @(posedge clock);
      case (index)
         lbps_pkg::CSR_READ_LATENCY:  rd_latency = value[lbps_pkg::LAT_W-1:0];
         lbps_pkg::CSR_WRITE_LATENCY: wr_latency = value[lbps_pkg::LAT_W-1:0];
         lbps_pkg::CSR_CLOCK_PERIOD:  period_ticks = value[lbps_pkg::PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // Load all three registers; latency words carry junk in the unused upper byte
   task automatic set_config(input logic [lbps_pkg::LAT_W-1:0] rd_lat,
                             input logic [lbps_pkg::LAT_W-1:0] wr_lat,
                             input logic [lbps_pkg::PERIOD_W-1:0] period);
      write_register(lbps_pkg::CSR_READ_LATENCY, {8'($urandom), rd_lat});
      write_register(lbps_pkg::CSR_WRITE_LATENCY, {8'($urandom), wr_lat});
      write_register(lbps_pkg::CSR_CLOCK_PERIOD, period);
   endtask

   // Send one request word; start stays high on return
   task automatic send_request(input logic kind, input logic [lbps_pkg::COUNT_W-1:0] accesses,
                               input logic [lbps_pkg::TICK_W-1:0] now);
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         // Half the gaps land after the block goes idle, the rest while it works
         if ($urandom_range(0, 1) == 1) begin
            do @(posedge clock); while (busy);
         end
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start            <= 1'b1;
      req_type         <= kind;
      req_access_count <= accesses;
      req_now_tick     <= now;
      do @(posedge clock); while (busy);
      pending_grants.push_back(book_port(kind, accesses, now));
   endtask

   // Compare each strobed result with the oldest booked grant
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_strobe) begin
         if (pending_grants.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result delay %0d port %0d", $realtime,
                        rsp_delay_cycles, rsp_port_index);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_delay_cycles !== want.delay_cycles || rsp_port_index !== want.port_index)
            begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: expected delay %0d port %0d, got delay %0d port %0d",
                           $realtime, want.delay_cycles, want.port_index,
                           rsp_delay_cycles, rsp_port_index);
            end
         end
      end
   end

   // Default registers, tie to the lowest port, idle port moved up to now
   task automatic test_reset_defaults();
      send_request(lbps_pkg::REQ_READ, 10'd1, 48'd0);
      send_request(lbps_pkg::REQ_READ, 10'd1, 48'd0);
      send_request(lbps_pkg::REQ_WRITE, 10'd1023, 48'd0);
      send_request(lbps_pkg::REQ_READ, 10'd0, 48'd500);
   endtask

   // Zero latency and zero accesses book nothing; an early tick still waits
   task automatic test_zero_work();
      write_register(lbps_pkg::CSR_READ_LATENCY, 16'd0);
      send_request(lbps_pkg::REQ_READ, 10'd1023, 48'd2000);
      send_request(lbps_pkg::REQ_WRITE, 10'd0, 48'd1500);
      send_request(lbps_pkg::REQ_READ, 10'd5, 48'd0);
   endtask

   // Load every read port deep, then shrink the period so the wait overflows
   task automatic test_saturated_wait();
      set_config(8'd255, 8'd255, 16'd65535);
      for (int i = 0; i < 2 * READ_PORTS; i++)
         send_request(lbps_pkg::REQ_READ, 10'd1023, 48'd10000);
      send_request(lbps_pkg::REQ_WRITE, 10'd1023, 48'd10000);
      write_register(lbps_pkg::CSR_CLOCK_PERIOD, 16'd1);
      send_request(lbps_pkg::REQ_READ, 10'd1023, 48'd10000);
   endtask

   // A zero period adds no work and the wait comes back in ticks
   task automatic test_zero_period();
      write_register(lbps_pkg::CSR_CLOCK_PERIOD, 16'd0);
      send_request(lbps_pkg::REQ_READ, 10'd7, 48'd20000);
      send_request(lbps_pkg::REQ_WRITE, 10'd1023, 48'd20000);
      send_request(lbps_pkg::REQ_WRITE, 10'd300, 48'd1000);
   endtask

   // One register setting, then a stream of requests on a mostly rising tick
   task automatic run_traffic(input logic [lbps_pkg::LAT_W-1:0] rd_lat,
                              input logic [lbps_pkg::LAT_W-1:0] wr_lat,
                              input logic [lbps_pkg::PERIOD_W-1:0] period,
                              input bit jump_high);
      longint unsigned    unit;
      longint unsigned    now;
      int                 lat_max;
      int                 pick;
      logic [lbps_pkg::COUNT_W-1:0] accesses;
      set_config(rd_lat, wr_lat, period);
      write_register(CSR_UNMAPPED, 16'($urandom));
      if (jump_high)
         tick_cursor = 64'h8000_0000_0000 | ({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF);
      lat_max = (rd_lat > wr_lat) ? rd_lat : wr_lat;
      if (lat_max == 0) lat_max = 1;
      unit = longint'(lat_max) * ((period == 0) ? 64'd1 : 64'(period));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0:       accesses = '0;
            1:       accesses = '1;
            default: accesses = lbps_pkg::COUNT_W'($urandom_range(0, 1023));
         endcase
         // Advance time near the rate the ports drain, so some requests queue
         tick_cursor = tick_cursor + unit * $urandom_range(0, 160);
         now = tick_cursor;
         if (pick == 2) now = tick_cursor - unit * $urandom_range(0, 400);
         send_request(logic'($urandom_range(0, 1)), accesses, lbps_pkg::TICK_W'(now));
      end
   endtask

   task automatic test_random_traffic();
      tick_cursor = 64'h10_0000_0000 + $urandom;
      run_traffic(8'd1, 8'd1, 16'd1000, 1'b0);
      run_traffic(8'd0, 8'd255, 16'd1, 1'b0);
      run_traffic(8'd255, 8'd0, 16'd65535, 1'b0);
      run_traffic(lbps_pkg::LAT_W'($urandom), lbps_pkg::LAT_W'($urandom),
                  lbps_pkg::PERIOD_W'($urandom_range(1, 65535)), 1'b0);
      run_traffic(8'd255, 8'd255, 16'd1, 1'b0);
      run_traffic(lbps_pkg::LAT_W'($urandom), lbps_pkg::LAT_W'($urandom), 16'd0, 1'b0);
      // Closing stretch runs without sender gaps and with the upper tick bits set
      sender_gaps_on = 1'b0;
      run_traffic(lbps_pkg::LAT_W'($urandom), lbps_pkg::LAT_W'($urandom),
                  lbps_pkg::PERIOD_W'($urandom_range(1, 65535)), 1'b1);
   endtask

   // Free ticks clamp at the top of the tick range
   task automatic test_tick_overflow();
      set_config(8'd255, 8'd255, 16'd65535);
      send_request(lbps_pkg::REQ_WRITE, 10'd1023, lbps_pkg::TICK_MAX - 48'd1000);
      send_request(lbps_pkg::REQ_WRITE, 10'd1023, lbps_pkg::TICK_MAX);
      send_request(lbps_pkg::REQ_READ, 10'd1023, lbps_pkg::TICK_MAX);
   endtask

   initial begin
      int drain_cycles;
      for (int i = 0; i < READ_PORTS; i++) read_free_at[i] = '0;
      for (int i = 0; i < WRITE_PORTS; i++) write_free_at[i] = '0;
      rd_latency   = lbps_pkg::LAT_RESET;
      wr_latency   = lbps_pkg::LAT_RESET;
      period_ticks = lbps_pkg::PERIOD_RESET;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_type         <= lbps_pkg::REQ_READ;
      req_access_count <= '0;
      req_now_tick     <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= lbps_pkg::CSR_READ_LATENCY;
      csr_data         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_work();
      test_saturated_wait();
      test_zero_period();
      test_random_traffic();
      test_tick_overflow();

      // Drain outstanding grants, then watch for stray strobes
      start <= 1'b0;
      drain_cycles = 0;
      while (pending_grants.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_grants.size() != 0)
         $display("%0d expected results never arrived", pending_grants.size());
      if (mismatch_count == 0 && pending_grants.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", pending_grants.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
